// File: design/tlfq_pkg.sv
// shared types, constants and helpers for the three level feedback queue scheduler
// no dependencies; imported by every module of the block
package tlfq_pkg;

	localparam int LEVEL_DEPTH = 16;
	localparam int NUM_LEVELS  = 3;
	localparam int PTR_W       = $clog2(LEVEL_DEPTH);
	localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
	localparam int SUM_W       = CNT_W + 2;
	localparam int LVL_IDX_W   = 2;
	localparam int ID_W        = 16;
	localparam int TICKS_W     = 16;
	localparam int QUANT_W     = 8;
	localparam int WAIT_W      = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LEVEL_DEPTH);

	// level codes as reported on the result item
	localparam logic [1:0] LVL_NONE  = 2'd0;
	localparam logic [1:0] LVL_ONE   = 2'd1;
	localparam logic [1:0] LVL_TWO   = 2'd2;
	localparam logic [1:0] LVL_THREE = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_THR = 2'd3;

	localparam logic POLICY_FCFS     = 1'b0;
	localparam logic POLICY_FEEDBACK = 1'b1;

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_TICK   = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [ID_W-1:0]    proc_ident;
		logic [TICKS_W-1:0] service_ticks;
	} in_item_t;

	typedef struct packed {
		logic              accepted;
		logic              dispatched;
		logic [ID_W-1:0]   dispatched_ident;
		logic [1:0]        dispatched_level;
		logic              retired;
		logic [ID_W-1:0]   retired_ident;
		logic              demoted;
		logic              cpu_busy;
		logic [WAIT_W-1:0] waiting_total;
	} out_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    ident;
		logic [TICKS_W-1:0] remaining;
	} entry_t;

	typedef struct packed {
		logic               policy_mode;
		logic [QUANT_W-1:0] quantum_one;
		logic [QUANT_W-1:0] quantum_two;
		logic [QUANT_W-1:0] quantum_three;
	} cfg_t;

	// queue controls from the scheduler core to the three level queues
	typedef struct packed {
		logic [NUM_LEVELS-1:0] push;
		logic [NUM_LEVELS-1:0] pop;
		entry_t                push_entry;
	} fifo_ctrl_t;

	function automatic logic [QUANT_W-1:0] quantum_sel(input logic [1:0] lvl, input cfg_t c);
		logic [QUANT_W-1:0] q;
		case (lvl)
			LVL_ONE: q = c.quantum_one;
			LVL_TWO: q = c.quantum_two;
			default: q = c.quantum_three;
		endcase
		return q;
	endfunction

endpackage

// File: design/tlfq_cfg_regs.sv
// configuration registers: policy mode and the three level quanta
// depends on tlfq_pkg
module tlfq_cfg_regs
	import tlfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy_mode   <= POLICY_FEEDBACK;
			cfg_q.quantum_one   <= QUANT_W'(4);
			cfg_q.quantum_two   <= QUANT_W'(8);
			cfg_q.quantum_three <= QUANT_W'(12);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLICY_MODE: cfg_q.policy_mode   <= cfg_data[0];
				CFG_QUANTUM_ONE: cfg_q.quantum_one   <= cfg_data[QUANT_W-1:0];
				CFG_QUANTUM_TWO: cfg_q.quantum_two   <= cfg_data[QUANT_W-1:0];
				CFG_QUANTUM_THR: cfg_q.quantum_three <= cfg_data[QUANT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/tlfq_level_fifo.sv
// one level queue: ring memory with head entry prefetched into a register
// depends on tlfq_pkg
module tlfq_level_fifo
	import tlfq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	input  entry_t           push_entry,
	output entry_t           head_entry,
	output logic [CNT_W-1:0] count
);

	entry_t           mem [LEVEL_DEPTH];
	entry_t           head_data_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_nx;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] head_inc;

	assign head_inc = (head_q == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_nx  = pop ? head_inc : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_inc;
			if (push)
				tail_q <= tail_inc;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[tail_q] <= push_entry;
	end

	// read ahead at the next head, taking the incoming item when it lands there
	always_ff @(posedge clk) begin
		if (push && (tail_q == head_nx))
			head_data_q <= push_entry;
		else
			head_data_q <= mem[head_nx];
	end

	assign head_entry = head_data_q;
	assign count      = count_q;

endmodule

// File: design/tlfq_core.sv
// scheduler core: running process state, dispatch, time advance, retire and demote
// depends on tlfq_pkg; drives the level queues through fifo_ctrl_t
module tlfq_core
	import tlfq_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  in_item_t                           item,
	input  cfg_t                               cfg,
	input  logic [NUM_LEVELS-1:0][CNT_W-1:0]   counts,
	input  entry_t [NUM_LEVELS-1:0]            heads,
	output fifo_ctrl_t                         ctrl,
	output out_item_t                          result
);

	logic               busy_q;
	logic [ID_W-1:0]    ident_q;
	logic [TICKS_W-1:0] rem_q;
	logic [QUANT_W-1:0] slice_q;
	logic [1:0]         level_q;

	logic               n_busy;
	logic [ID_W-1:0]    n_ident;
	logic [TICKS_W-1:0] n_rem;
	logic [QUANT_W-1:0] n_slice;
	logic [1:0]         n_level;
	logic               have_disp;
	logic [LVL_IDX_W-1:0] disp_idx;
	logic [1:0]           tgt_lvl;
	logic [LVL_IDX_W-1:0] tgt_idx;
	logic                 tgt_full;
	logic [SUM_W-1:0]     wait_sum;

	always_comb begin
		ctrl      = '0;
		result    = '0;
		n_busy    = busy_q;
		n_ident   = ident_q;
		n_rem     = rem_q;
		n_slice   = slice_q;
		n_level   = level_q;
		have_disp = 1'b0;
		disp_idx  = '0;
		tgt_lvl   = LVL_THREE;
		tgt_idx   = '0;
		tgt_full  = 1'b0;

		if (fire) begin
			if (item.opcode == OP_ARRIVE) begin
				if (item.service_ticks != '0 && counts[0] != DEPTH_CNT) begin
					ctrl.push[0]              = 1'b1;
					ctrl.push_entry.ident     = item.proc_ident;
					ctrl.push_entry.remaining = item.service_ticks;
					result.accepted           = 1'b1;
				end
			end else begin
				result.accepted = 1'b1;
				// highest non-empty level wins
				if (!busy_q) begin
					if (counts[0] != '0) begin
						have_disp = 1'b1;
						disp_idx  = LVL_IDX_W'(0);
					end else if (counts[1] != '0) begin
						have_disp = 1'b1;
						disp_idx  = LVL_IDX_W'(1);
					end else if (counts[2] != '0) begin
						have_disp = 1'b1;
						disp_idx  = LVL_IDX_W'(2);
					end
				end
				if (have_disp) begin
					ctrl.pop[disp_idx]      = 1'b1;
					n_ident                 = heads[disp_idx].ident;
					n_rem                   = heads[disp_idx].remaining;
					n_level                 = disp_idx + 1'b1;
					n_slice                 = cfg.policy_mode ? quantum_sel(n_level, cfg) : '0;
					n_busy                  = 1'b1;
					result.dispatched       = 1'b1;
					result.dispatched_ident = n_ident;
					result.dispatched_level = n_level;
				end
				if (n_busy) begin
					n_rem = (n_rem != '0) ? n_rem - 1'b1 : '0;
					if (cfg.policy_mode && n_slice != '0)
						n_slice = n_slice - 1'b1;
					if (n_rem == '0) begin
						result.retired       = 1'b1;
						result.retired_ident = n_ident;
						n_busy               = 1'b0;
						n_level              = LVL_NONE;
						n_slice              = '0;
					end else if (cfg.policy_mode && n_slice == '0) begin
						tgt_lvl  = (n_level == LVL_ONE) ? LVL_TWO : LVL_THREE;
						tgt_idx  = tgt_lvl - 1'b1;
						// a pop from the target this tick frees a slot first
						tgt_full = (counts[tgt_idx] == DEPTH_CNT) && !ctrl.pop[tgt_idx];
						if (!tgt_full) begin
							ctrl.push[tgt_idx]        = 1'b1;
							ctrl.push_entry.ident     = n_ident;
							ctrl.push_entry.remaining = n_rem;
							result.demoted            = 1'b1;
							n_busy                    = 1'b0;
							n_level                   = LVL_NONE;
						end else begin
							n_level = tgt_lvl;
							n_slice = quantum_sel(tgt_lvl, cfg);
						end
					end
				end
			end
			result.cpu_busy = n_busy;
		end

		wait_sum = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			wait_sum = wait_sum + SUM_W'(counts[i]) + SUM_W'(ctrl.push[i])
				- SUM_W'(ctrl.pop[i]);
		end
		result.waiting_total = WAIT_W'(wait_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ident_q <= '0;
			rem_q   <= '0;
			slice_q <= '0;
			level_q <= LVL_NONE;
		end else if (fire) begin
			busy_q  <= n_busy;
			ident_q <= n_ident;
			rem_q   <= n_rem;
			slice_q <= n_slice;
			level_q <= n_level;
		end
	end

endmodule

// File: design/three_level_feedback_queue_scheduler.sv
// Three level feedback queue scheduler, tick driven.
// Input channel (in_valid / in_stall / in_data): each item is an arrive, which
// queues a process at level one, or a tick, which dispatches from the highest
// non-empty level when the processor is idle and then advances time by one.
// Output channel (out_valid / out_stall / out_data): exactly one result item per
// input item, in order.
// Configuration (cfg_we / cfg_index / cfg_data): policy mode and three quanta; the user
// must see that it is written only while no item is in flight, as the block does not enforce this.
// An item taken is held in the input register, worked on by the core and then
// stored in the result register. One item per cycle is sustained while out_stall
// is low: the queue heads are read ahead into registers, so the core needs no
// memory read of its own.
// Reset clears queue pointers, counts and the running process; queue memory is
// not cleared and no clearing pass is needed. Configuration returns to feedback
// mode with quanta 4, 8 and 12.
// When out_stall is high with a result waiting, the next item waits in the input
// register and in_stall rises until the result is taken.
// depends on tlfq_pkg, tlfq_cfg_regs, tlfq_level_fifo, tlfq_core
module three_level_feedback_queue_scheduler
	import tlfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                             valid_s1;
	in_item_t                         item_s1;
	logic                             out_valid_q;
	out_item_t                        out_item_q;
	logic                             advance;
	logic                             fire;
	cfg_t                             cfg;
	fifo_ctrl_t                       ctrl;
	out_item_t                        result;
	logic [NUM_LEVELS-1:0][CNT_W-1:0] counts;
	entry_t [NUM_LEVELS-1:0]          heads;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_item_q <= result;
	end

	tlfq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
		tlfq_level_fifo u_fifo (
			.clk        (clk),
			.arst_n     (arst_n),
			.push       (ctrl.push[g]),
			.pop        (ctrl.pop[g]),
			.push_entry (ctrl.push_entry),
			.head_entry (heads[g]),
			.count      (counts[g])
		);
	end

	tlfq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.counts (counts),
		.heads  (heads),
		.ctrl   (ctrl),
		.result (result)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

// File: sim/tlfq_result_monitor.sv
`timescale 1ns / 1ps
// result monitor for the three level feedback queue scheduler: watches both channels
// and the register port, predicts every result item and compares it; uses tlfq_pkg
module tlfq_result_monitor
	import tlfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    results_due_count,
	output int                    err_count,
	output int                    retire_count,
	output int                    demote_count,
	output int                    reject_count,
	output int                    held_count
);

	// scheduler state as predicted
	entry_t             ring [NUM_LEVELS][LEVEL_DEPTH];
	int unsigned        ring_head [NUM_LEVELS];
	int unsigned        ring_tail [NUM_LEVELS];
	int unsigned        ring_count [NUM_LEVELS];
	bit                 running;
	logic [ID_W-1:0]    run_ident;
	logic [TICKS_W-1:0] run_left;
	logic [QUANT_W-1:0] slice;
	logic [1:0]         run_level;
	cfg_t               sched_cfg;

	out_item_t sched_results_due [$];
	out_item_t seen_result;
	out_item_t want_result;
	out_item_t fresh_result;

	task automatic report(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want) begin
			report($sformatf("%s got %h expected %h", name, got, want));
		end
	endtask

	function automatic logic [QUANT_W-1:0] slice_for(input logic [1:0] lvl);
		case (lvl)
			LVL_ONE: return sched_cfg.quantum_one;
			LVL_TWO: return sched_cfg.quantum_two;
			default: return sched_cfg.quantum_three;
		endcase
	endfunction

	function automatic bit level_push(input int lv, input entry_t e);
		if (ring_count[lv] >= LEVEL_DEPTH) begin
			return 1'b0;
		end
		ring[lv][ring_tail[lv]] = e;
		ring_tail[lv] = (ring_tail[lv] + 1 == LEVEL_DEPTH) ? 0 : ring_tail[lv] + 1;
		ring_count[lv]++;
		return 1'b1;
	endfunction

	function automatic entry_t level_pop(input int lv);
		entry_t e;
		e = ring[lv][ring_head[lv]];
		ring_head[lv] = (ring_head[lv] + 1 == LEVEL_DEPTH) ? 0 : ring_head[lv] + 1;
		ring_count[lv]--;
		return e;
	endfunction

	task automatic schedule_step(input in_item_t it, output out_item_t r);
		int         lv;
		bit         found;
		logic [1:0] target;
		entry_t     e;
		bit         feedback;
		r = '0;
		feedback = (sched_cfg.policy_mode == POLICY_FEEDBACK);
		if (it.opcode == OP_ARRIVE) begin
			if (it.service_ticks != '0) begin
				r.accepted = level_push(0, {it.proc_ident, it.service_ticks});
			end
			if (!r.accepted) begin
				reject_count++;
			end
		end else begin
			r.accepted = 1'b1;
			if (!running) begin
				found = 1'b0;
				for (lv = 0; lv < NUM_LEVELS; lv++) begin
					if (!found && ring_count[lv] != 0) begin
						e = level_pop(lv);
						run_ident = e.ident;
						run_left = e.remaining;
						run_level = 2'(lv + 1);
						slice = feedback ? slice_for(run_level) : '0;
						running = 1'b1;
						r.dispatched = 1'b1;
						r.dispatched_ident = e.ident;
						r.dispatched_level = run_level;
						found = 1'b1;
					end
				end
			end
			if (running) begin
				if (run_left != '0) begin
					run_left--;
				end
				if (feedback && slice != '0) begin
					slice--;
				end
				// retirement wins over an expired slice
				if (run_left == '0) begin
					r.retired = 1'b1;
					r.retired_ident = run_ident;
					running = 1'b0;
					run_level = LVL_NONE;
					slice = '0;
					retire_count++;
				end else if (feedback && slice == '0) begin
					target = (run_level == LVL_ONE) ? LVL_TWO : LVL_THREE;
					if (level_push(int'(target) - 1, {run_ident, run_left})) begin
						r.demoted = 1'b1;
						running = 1'b0;
						run_level = LVL_NONE;
						demote_count++;
					end else begin
						// lower level full: job stays on the cpu with the new slice
						run_level = target;
						slice = slice_for(target);
						held_count++;
					end
				end
			end
		end
		r.cpu_busy = running;
		r.waiting_total = WAIT_W'(ring_count[0] + ring_count[1] + ring_count[2]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				ring_head[i] = 0;
				ring_tail[i] = 0;
				ring_count[i] = 0;
			end
			running = 1'b0;
			run_ident = '0;
			run_left = '0;
			slice = '0;
			run_level = LVL_NONE;
			sched_cfg.policy_mode = POLICY_FEEDBACK;
			sched_cfg.quantum_one = 8'd4;
			sched_cfg.quantum_two = 8'd8;
			sched_cfg.quantum_three = 8'd12;
			sched_results_due.delete();
			results_due_count = 0;
			err_count = 0;
			retire_count = 0;
			demote_count = 0;
			reject_count = 0;
			held_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_result = out_data;
				if (sched_results_due.size() == 0) begin
					report("result item with nothing expected");
				end else begin
					want_result = sched_results_due.pop_front();
					check_field("accepted", 16'(seen_result.accepted),
						16'(want_result.accepted));
					check_field("dispatched", 16'(seen_result.dispatched),
						16'(want_result.dispatched));
					check_field("dispatched_ident", seen_result.dispatched_ident,
						want_result.dispatched_ident);
					check_field("dispatched_level", 16'(seen_result.dispatched_level),
						16'(want_result.dispatched_level));
					check_field("retired", 16'(seen_result.retired),
						16'(want_result.retired));
					check_field("retired_ident", seen_result.retired_ident,
						want_result.retired_ident);
					check_field("demoted", 16'(seen_result.demoted),
						16'(want_result.demoted));
					check_field("cpu_busy", 16'(seen_result.cpu_busy),
						16'(want_result.cpu_busy));
					check_field("waiting_total", 16'(seen_result.waiting_total),
						16'(want_result.waiting_total));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLICY_MODE: sched_cfg.policy_mode = cfg_data[0];
					CFG_QUANTUM_ONE: sched_cfg.quantum_one = cfg_data;
					CFG_QUANTUM_TWO: sched_cfg.quantum_two = cfg_data;
					CFG_QUANTUM_THR: sched_cfg.quantum_three = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				schedule_step(in_data, fresh_result);
				sched_results_due.push_back(fresh_result);
			end
			results_due_count = sched_results_due.size();
		end
	end

endmodule

// File: sim/tb_three_level_feedback_queue_scheduler.sv
`timescale 1ns / 1ps
// testbench top for the three level feedback queue scheduler: clock, reset, stimulus
// phases and verdict; depends on tlfq_pkg, the block and tlfq_result_monitor
module tb_three_level_feedback_queue_scheduler;
	import tlfq_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 62;

	localparam int IDLE_NONE   = 0;
	localparam int IDLE_SENDER = 1;
	localparam int IDLE_RECV   = 2;
	localparam int IDLE_BOTH   = 3;

	localparam int SVC_SHORT = 0;
	localparam int SVC_MIXED = 1;
	localparam int SVC_LONG  = 2;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int results_due_count;
	int err_count;
	int retire_count;
	int demote_count;
	int reject_count;
	int held_count;

	int cycle_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	three_level_feedback_queue_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tlfq_result_monitor result_monitor (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_data           (in_data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_data          (out_data),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.results_due_count (results_due_count),
		.err_count         (err_count),
		.retire_count      (retire_count),
		.demote_count      (demote_count),
		.reject_count      (reject_count),
		.held_count        (held_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic in_item_t make_item(input opcode_t op, input logic [ID_W-1:0] id,
		input logic [TICKS_W-1:0] svc);
		in_item_t it;
		it.opcode = op;
		it.proc_ident = id;
		it.service_ticks = svc;
		return it;
	endfunction

	function automatic logic [TICKS_W-1:0] pick_service(input int kind);
		int r;
		r = $urandom_range(99);
		if (r < 4) begin
			return '0;
		end
		if (r < 10) begin
			return TICKS_W'($urandom);
		end
		case (kind)
			SVC_SHORT: return TICKS_W'($urandom_range(1, 8));
			SVC_MIXED: return TICKS_W'($urandom_range(1, 64));
			default:   return TICKS_W'($urandom_range(40, 400));
		endcase
	endfunction

	task automatic set_idling(input int mode);
		case (mode)
			IDLE_SENDER: begin
				send_idle_pct = 76;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 76;
			end
			IDLE_BOTH: begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// called at a rising edge; returns at the edge where the item was taken
	task automatic send_item(input in_item_t it);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_due_count != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic mode, input logic [QUANT_W-1:0] q1,
		input logic [QUANT_W-1:0] q2, input logic [QUANT_W-1:0] q3);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = CFG_POLICY_MODE;
		idx[1] = CFG_QUANTUM_ONE;
		idx[2] = CFG_QUANTUM_TWO;
		idx[3] = CFG_QUANTUM_THR;
		// upper bits of the mode write are junk and must be dropped
		val[0] = (CFG_DATA_W'($urandom) & 8'hFE) | CFG_DATA_W'(mode);
		val[1] = q1;
		val[2] = q2;
		val[3] = q3;
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int               ph;
		int               n;
		int               burst;
		int               arr_pct;
		int               svc_kind;
		opcode_t          op;
		logic             m;
		logic [QUANT_W-1:0] q1;
		logic [QUANT_W-1:0] q2;
		logic [QUANT_W-1:0] q3;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, a rejected arrival, field extremes, retire on first tick,
		// demotion from each level and level three back to itself
		write_config(POLICY_FEEDBACK, 8'd2, 8'd3, 8'd1);
		send_item(make_item(OP_TICK, 16'hFFFF, 16'hFFFF));
		send_item(make_item(OP_ARRIVE, 16'h0000, 16'h0000));
		send_item(make_item(OP_ARRIVE, 16'hFFFF, 16'h0001));
		send_item(make_item(OP_ARRIVE, 16'h1234, 16'hFFFF));
		send_item(make_item(OP_ARRIVE, 16'h0000, 16'h0003));
		repeat (12) send_item(make_item(OP_TICK, 16'h0000, 16'h0000));
		send_item(make_item(OP_ARRIVE, 16'hA5C3, 16'h8000));
		send_item(make_item(OP_TICK, 16'hFFFF, 16'h0000));
		wait_drained();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:  begin m = POLICY_FEEDBACK; q1 = 8'd1; q2 = 8'd1; q3 = 8'd1; end
				1:  begin m = POLICY_FEEDBACK; q1 = 8'd1; q2 = 8'd1; q3 = 8'd1; end
				2:  begin m = POLICY_FCFS; q1 = 8'd9; q2 = 8'd9; q3 = 8'd9; end
				3:  begin m = POLICY_FEEDBACK; q1 = 8'd0; q2 = 8'd0; q3 = 8'd0; end
				4:  begin m = POLICY_FEEDBACK; q1 = 8'd255; q2 = 8'd255; q3 = 8'd255; end
				5:  begin m = POLICY_FCFS; q1 = 8'd255; q2 = 8'd0; q3 = 8'd128; end
				6:  begin m = POLICY_FEEDBACK; q1 = 8'd2; q2 = 8'd3; q3 = 8'd5; end
				7:  begin m = POLICY_FEEDBACK; q1 = 8'd1; q2 = 8'd2; q3 = 8'd1; end
				8:  begin m = POLICY_FEEDBACK; q1 = 8'd4; q2 = 8'd8; q3 = 8'd12; end
				9:  begin m = POLICY_FCFS; q1 = 8'd1; q2 = 8'd1; q3 = 8'd1; end
				10: begin
					m = POLICY_FEEDBACK;
					q1 = QUANT_W'($urandom);
					q2 = QUANT_W'($urandom);
					q3 = QUANT_W'($urandom);
				end
				default: begin m = POLICY_FEEDBACK; q1 = 8'd3; q2 = 8'd1; q3 = 8'd0; end
			endcase
			case (ph)
				0:       begin arr_pct = 65; svc_kind = SVC_LONG;  end
				1:       begin arr_pct = 55; svc_kind = SVC_LONG;  end
				2:       begin arr_pct = 35; svc_kind = SVC_MIXED; end
				3:       begin arr_pct = 45; svc_kind = SVC_MIXED; end
				4:       begin arr_pct = 30; svc_kind = SVC_MIXED; end
				5:       begin arr_pct = 55; svc_kind = SVC_SHORT; end
				6:       begin arr_pct = 60; svc_kind = SVC_LONG;  end
				7:       begin arr_pct = 60; svc_kind = SVC_LONG;  end
				8:       begin arr_pct = 50; svc_kind = SVC_SHORT; end
				9:       begin arr_pct = 40; svc_kind = SVC_MIXED; end
				10:      begin arr_pct = 50; svc_kind = SVC_MIXED; end
				default: begin arr_pct = 25; svc_kind = SVC_SHORT; end
			endcase
			write_config(m, q1, q2, q3);
			set_idling(ph % 4);
			n = 0;
			// runs of arrivals or ticks, so levels fill up and then drain
			while (n < ITEMS_PER_PHASE) begin
				op = ($urandom_range(99) < arr_pct) ? OP_ARRIVE : OP_TICK;
				burst = $urandom_range(1, 6);
				while (burst > 0 && n < ITEMS_PER_PHASE) begin
					if (op == OP_ARRIVE) begin
						send_item(make_item(OP_ARRIVE, ID_W'($urandom),
							pick_service(svc_kind)));
					end else begin
						send_item(make_item(OP_TICK, ID_W'($urandom), TICKS_W'($urandom)));
					end
					burst--;
					n++;
				end
			end
			wait_drained();
		end

		set_idling(IDLE_NONE);
		repeat (10) @(posedge clk);
		$display("covered %0d items over %0d register settings: %0d retired, %0d demoted",
			items_sent, NUM_PHASES + 1, retire_count, demote_count);
		$display("arrivals rejected %0d, demotions held by a full level %0d",
			reject_count, held_count);
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
design/tlfq_pkg.sv
design/tlfq_cfg_regs.sv
design/tlfq_level_fifo.sv
design/tlfq_core.sv
design/three_level_feedback_queue_scheduler.sv
sim/tlfq_result_monitor.sv
sim/tb_three_level_feedback_queue_scheduler.sv
